### rtl/core/assert_macros.svh
// Assertion macros shared by the converter's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// Check that post holds whenever pre holds, outside reset.
`define ASSERT_IMPLIES(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication violated");

`endif

### rtl/core/ekc_pkg.sv
// Types, codes and constants of the EUC-KR / ISO-2022-KR converter.
package ekc_pkg;

    // Function codes of an input beat
    localparam logic [1:0] FUNC_SCAN = 2'd0;
    localparam logic [1:0] FUNC_CONV = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    // Direction register values
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Character codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SO    = 8'h0E;
    localparam logic [7:0] CH_SI    = 8'h0F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_STOP  = 8'hFF;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] KSC_LOW  = 8'hA0;
    localparam logic [7:0] MASK_7B  = 8'h7F;
    localparam logic [7:0] BIT_HI   = 8'h80;

    // Result bytes carried by one command
    localparam int MAX_BYTES = 5;
    localparam int CNT_W     = 3;

    // Default command queue depth
    localparam int EKC_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_t;

    // Command from front to back: byte count and bytes, entry 0 goes first
    typedef struct packed {
        logic [CNT_W-1:0]               count;
        logic [MAX_BYTES-1:0][7:0]      bytes;
    } cmd_t;

    // Byte k of the designator ESC $ ) C
    function automatic logic [7:0] desig_byte(input logic [1:0] k);
        logic [7:0] d;
        case (k)
            2'd0:    d = 8'h1B;
            2'd1:    d = 8'h24;
            2'd2:    d = 8'h29;
            default: d = 8'h43;
        endcase
        return d;
    endfunction

    function automatic logic is_ksc(input logic [7:0] b);
        return (b > KSC_LOW) && (b != CH_STOP);
    endfunction

endpackage

### rtl/core/ekc_front.sv
// Front end: accepts input beats, tracks line state and builds output commands.
module ekc_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           accept,
    input  ekc_pkg::in_t   in_data,
    output logic           push,
    output ekc_pkg::cmd_t  cmd
);

    logic       dir_reg;
    logic       hangul_reg,  hangul_next;
    logic       shift_reg,   shift_next;
    logic       stopped_reg, stopped_next;
    logic [1:0] pend_reg,    pend_next;
    logic       start_reg,   start_next;
    logic       mfs_reg,     mfs_next;
    logic       drop_reg,    drop_next;

    // Classify the beat and collect its result bytes
    always_comb
    begin
        logic [ekc_pkg::CNT_W-1:0]          n;
        logic [ekc_pkg::MAX_BYTES-1:0][7:0] ob;
        logic [7:0]                         b;
        logic [7:0]                         dplain;
        logic                               sm;
        logic                               st;
        logic                               done;

        hangul_next  = hangul_reg;
        shift_next   = shift_reg;
        stopped_next = stopped_reg;
        pend_next    = pend_reg;
        start_next   = start_reg;
        mfs_next     = mfs_reg;
        drop_next    = drop_reg;
        n            = '0;
        ob           = '0;
        b            = in_data.data_byte;
        dplain       = '0;
        sm           = shift_reg;
        st           = stopped_reg;
        done         = 1'b0;

        if (accept)
        begin
            case (in_data.func)
                ekc_pkg::FUNC_END:
                begin
                    if (dir_reg == ekc_pkg::DIR_DECODE)
                    begin
                        // Release held designator bytes as plain bytes
                        if (!stopped_reg)
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                if (2'(k) < pend_reg)
                                begin
                                    dplain = ekc_pkg::desig_byte(2'(k));
                                    ob[n]  = (hangul_reg && shift_reg) ?
                                             (dplain | ekc_pkg::BIT_HI) : dplain;
                                    n      = n + 3'd1;
                                end
                            end
                        end
                    end
                    else if (shift_reg && !stopped_reg)
                    begin
                        ob[n] = ekc_pkg::CH_SI;
                        n     = n + 3'd1;
                    end
                    shift_next   = 1'b0;
                    stopped_next = 1'b0;
                    pend_next    = '0;
                    mfs_next     = 1'b0;
                    drop_next    = 1'b0;
                    start_next   = 1'b1;
                end

                ekc_pkg::FUNC_SCAN:
                begin
                    // Scan pass: when encoding, send the designator and a newline on the first KSC byte
                    if (dir_reg == ekc_pkg::DIR_ENCODE && !hangul_reg && !stopped_reg)
                    begin
                        if (b == ekc_pkg::CH_NL || b == ekc_pkg::CH_STOP)
                        begin
                            stopped_next = 1'b1;
                        end
                        else if (ekc_pkg::is_ksc(b))
                        begin
                            hangul_next = 1'b1;
                            ob[0] = ekc_pkg::desig_byte(2'd0);
                            ob[1] = ekc_pkg::desig_byte(2'd1);
                            ob[2] = ekc_pkg::desig_byte(2'd2);
                            ob[3] = ekc_pkg::desig_byte(2'd3);
                            ob[4] = ekc_pkg::CH_NL;
                            n     = 3'd5;
                        end
                    end
                end

                ekc_pkg::FUNC_CONV:
                begin
                    if (dir_reg == ekc_pkg::DIR_DECODE)
                    begin
                        if (!stopped_reg)
                        begin
                            start_next = 1'b0;
                            // Drop a newline that follows a lone designator
                            if (drop_reg)
                            begin
                                drop_next = 1'b0;
                                if (b == ekc_pkg::CH_NL)
                                begin
                                    stopped_next = 1'b1;
                                    done         = 1'b1;
                                end
                            end
                            // Advance or break the designator match
                            if (!done && pend_reg != 2'd0)
                            begin
                                if (b == ekc_pkg::desig_byte(pend_reg))
                                begin
                                    if (pend_reg == 2'd3)
                                    begin
                                        pend_next   = '0;
                                        hangul_next = 1'b1;
                                        drop_next   = mfs_reg;
                                        mfs_next    = 1'b0;
                                    end
                                    else
                                    begin
                                        pend_next = pend_reg + 2'd1;
                                    end
                                    done = 1'b1;
                                end
                                else
                                begin
                                    for (int k = 0; k < 3; k++)
                                    begin
                                        if (2'(k) < pend_reg)
                                        begin
                                            dplain = ekc_pkg::desig_byte(2'(k));
                                            ob[n]  = (hangul_reg && shift_reg) ?
                                                     (dplain | ekc_pkg::BIT_HI) : dplain;
                                            n      = n + 3'd1;
                                        end
                                    end
                                    pend_next = '0;
                                    mfs_next  = 1'b0;
                                end
                            end
                            // Handle the byte itself
                            if (!done)
                            begin
                                if (b == ekc_pkg::CH_NL)
                                begin
                                    ob[n]        = b;
                                    n            = n + 3'd1;
                                    stopped_next = 1'b1;
                                end
                                else if (b == ekc_pkg::CH_STOP)
                                begin
                                    stopped_next = 1'b1;
                                end
                                else if (b == ekc_pkg::CH_ESC)
                                begin
                                    pend_next = 2'd1;
                                    mfs_next  = start_reg;
                                end
                                else if (!hangul_reg)
                                begin
                                    ob[n] = b;
                                    n     = n + 3'd1;
                                end
                                else if (b == ekc_pkg::CH_SO)
                                begin
                                    shift_next = 1'b1;
                                end
                                else if (b == ekc_pkg::CH_SI)
                                begin
                                    shift_next = 1'b0;
                                end
                                else if (!shift_reg || b == ekc_pkg::CH_SPACE ||
                                         b == ekc_pkg::CH_TAB)
                                begin
                                    ob[n] = b;
                                    n     = n + 3'd1;
                                end
                                else
                                begin
                                    ob[n] = b | ekc_pkg::BIT_HI;
                                    n     = n + 3'd1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        // First convert byte of a line restarts line state
                        if (start_reg)
                        begin
                            start_next = 1'b0;
                            st         = 1'b0;
                            sm         = 1'b0;
                        end
                        if (!hangul_reg)
                        begin
                            ob[n] = b;
                            n     = n + 3'd1;
                        end
                        else if (!st)
                        begin
                            if (b == ekc_pkg::CH_NL || b == ekc_pkg::CH_STOP)
                            begin
                                if (sm)
                                begin
                                    ob[n] = ekc_pkg::CH_SI;
                                    n     = n + 3'd1;
                                end
                                sm = 1'b0;
                                st = 1'b1;
                                if (b == ekc_pkg::CH_NL)
                                begin
                                    ob[n] = ekc_pkg::CH_NL;
                                    n     = n + 3'd1;
                                end
                            end
                            else if (ekc_pkg::is_ksc(b))
                            begin
                                if (!sm)
                                begin
                                    ob[n] = ekc_pkg::CH_SO;
                                    n     = n + 3'd1;
                                    sm    = 1'b1;
                                end
                                ob[n] = b & ekc_pkg::MASK_7B;
                                n     = n + 3'd1;
                            end
                            else
                            begin
                                if (sm)
                                begin
                                    ob[n] = ekc_pkg::CH_SI;
                                    n     = n + 3'd1;
                                    sm    = 1'b0;
                                end
                                ob[n] = b;
                                n     = n + 3'd1;
                            end
                        end
                        shift_next   = sm;
                        stopped_next = st;
                    end
                end

                default:
                begin
                end
            endcase
        end

        cmd.count = n;
        cmd.bytes = ob;
        push      = (n != '0);
    end

    // Hold line state and the direction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg     <= ekc_pkg::DIR_ENCODE;
            hangul_reg  <= 1'b0;
            shift_reg   <= 1'b0;
            stopped_reg <= 1'b0;
            pend_reg    <= '0;
            start_reg   <= 1'b1;
            mfs_reg     <= 1'b0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dir_reg <= cfg_wdata;
            end
            hangul_reg  <= hangul_next;
            shift_reg   <= shift_next;
            stopped_reg <= stopped_next;
            pend_reg    <= pend_next;
            start_reg   <= start_next;
            mfs_reg     <= mfs_next;
            drop_reg    <= drop_next;
        end
    end

endmodule

### rtl/core/ekc_queue.sv
// Command queue between the front end and the byte sender.
`include "assert_macros.svh"

module ekc_queue
#(
    parameter int DEPTH = ekc_pkg::EKC_QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ekc_pkg::cmd_t  push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output ekc_pkg::cmd_t  head_cmd
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ekc_pkg::cmd_t      mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_IMPLIES(a_no_push_when_full, push, count_reg != CNT_W'(DEPTH))
    `ASSERT_IMPLIES(a_no_pop_when_empty, pop, count_reg != '0)

endmodule

### rtl/core/ekc_back.sv
// Back end: sends the bytes of each queued command, one beat per cycle unless stalled.
`include "assert_macros.svh"

module ekc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  ekc_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output ekc_pkg::out_t  out_data
);

    logic                       cmd_valid_reg, cmd_valid_next;
    ekc_pkg::cmd_t              cmd_reg;
    logic [ekc_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                       last_byte;
    logic                       fire;
    logic                       load;

    assign last_byte = (idx_reg == (cmd_reg.count - 3'd1));
    assign fire      = cmd_valid_reg && !out_stall;
    assign load      = q_valid && (!cmd_valid_reg || (fire && last_byte));
    assign q_pop     = load;

    assign out_valid         = cmd_valid_reg;
    assign out_data.out_byte = cmd_reg.bytes[idx_reg];
    assign out_data.last     = last_byte;

    // Load the next command or step through the current one
    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cmd_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                cmd_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Capture the command payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= q_cmd;
        end
    end

    `ASSERT_IMPLIES(a_cmd_not_empty, cmd_valid_reg, cmd_reg.count != '0)
    `ASSERT_IMPLIES(a_idx_in_range, cmd_valid_reg, idx_reg < cmd_reg.count)

endmodule

### rtl/core/euckr_iso2022kr_converter.sv
// Top level of the EUC-KR / ISO-2022-KR line converter.
// An item's results go into the command queue, then into the sender's command register.
// Throughput: one input beat per cycle while the command queue has room; the sender
// puts out one byte per cycle while out_stall is low.
// Reset: rst_n clears all line state asynchronously, empties the queue, direction = encode.
module euckr_iso2022kr_converter
#(
    parameter int QDEPTH = ekc_pkg::EKC_QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    input  logic           in_valid,
    output logic           in_stall,
    input  ekc_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output ekc_pkg::out_t  out_data
);

    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    logic           push;
    logic           accept;
    ekc_pkg::cmd_t  push_cmd;
    ekc_pkg::cmd_t  head_cmd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    ekc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_data   (in_data),
        .push      (push),
        .cmd       (push_cmd)
    );

    ekc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    ekc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
